// ===== rtl/brab_pkg.sv =====
// Package for the branch resolve unit with its age-ordered result buffer.
// Holds the transaction payload types, condition codes and fixed field widths.
// Has no dependencies; the top level imports it.
`default_nettype none

package brab_pkg;

   localparam int WORD_W = 32;
   localparam int TAG_W  = 5;
   localparam int CMD_W  = 3;

   localparam logic [CMD_W-1:0] CMD_EQ  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_NE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LTU = 3'd4;
   localparam logic [CMD_W-1:0] CMD_GEU = 3'd5;

   localparam logic signed [WORD_W-1:0] PC_STEP = 32'sd4;

   typedef struct packed {
      logic                     dispatch_valid;
      logic [CMD_W-1:0]         cmd;
      logic signed [WORD_W-1:0] first_operand;
      logic signed [WORD_W-1:0] second_operand;
      logic signed [WORD_W-1:0] branch_pc;
      logic signed [WORD_W-1:0] offset;
      logic [TAG_W-1:0]         branch_tag;
      logic                     squash_valid;
      logic [TAG_W-1:0]         squash_tag;
      logic [TAG_W-1:0]         rob_head;
   } req_type;

   typedef struct packed {
      logic                     writeback_valid;
      logic signed [WORD_W-1:0] from_pc;
      logic signed [WORD_W-1:0] next_pc;
      logic [TAG_W-1:0]         result_tag;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/brab_chan_if.sv =====
// Valid/ready channel interface used for the request and response channels.
// The payload type is a parameter; the block passes the structs of brab_pkg.
`default_nettype none

interface brab_chan_if #(parameter type payload_type = logic) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/branch_resolve_with_age_buffer_core.sv =====
// Top level of the branch resolve unit with a small age-ordered result buffer.
// Depends on brab_pkg for payload types and on brab_chan_if for the channels.
//
// Usage:
// The req_bus channel carries one transaction per cycle while ready: an optional
// branch dispatch (condition, operands, pc, offset, reorder tag), an optional
// squash and the reorder-buffer head used as the age reference. Every request
// transaction produces exactly one response transaction on rsp_bus, which
// reports the oldest buffered branch (or all zeros when nothing is buffered).
// A request is captured in an input register and its response is loaded into
// the output register when it advances, which waits while the output holds an
// unaccepted response. Throughput is one transaction per cycle while the
// receiver keeps up, set by the single pass over the SLOTS-entry buffer that
// resolves, inserts, selects by age and squashes between the two registers.
// When the receiver stalls, the response holds in the output register and the
// input register keeps one more request; req_bus.ready drops once both are
// full. Synchronous reset empties the buffer and both registers.
`default_nettype none

module branch_resolve_with_age_buffer_core
   import brab_pkg::*;
#(
   parameter int SLOTS       = 4,
   parameter int ROB_ENTRIES = 32
) (
   input  wire logic     clock,
   input  wire logic     reset,
   brab_chan_if.sink     req_bus,
   brab_chan_if.source   rsp_bus
);

   localparam int AGE_W  = (ROB_ENTRIES > 1) ? $clog2(ROB_ENTRIES) : 1;
   localparam int SUM_W  = AGE_W + 1;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LVL    = (SLOTS > 1) ? $clog2(SLOTS) : 0;
   localparam int LEAVES = 1 << LVL;
   localparam int NODES  = 2 * LEAVES - 1;
   localparam int TAGS   = 1 << TAG_W;
   localparam logic [SUM_W-1:0] RANGE = SUM_W'(ROB_ENTRIES);

   req_type                  stage_ff;
   logic                     stage_valid_ff;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic                     rsp_valid_ff;
   logic                     advance;

   logic [SLOTS-1:0]         slot_busy_ff;
   logic [SLOTS-1:0]         slot_busy_in;
   logic signed [WORD_W-1:0] slot_from_pc_ff [SLOTS];
   logic signed [WORD_W-1:0] slot_next_pc_ff [SLOTS];
   logic [TAG_W-1:0]         slot_tag_ff     [SLOTS];

   logic                     taken;
   logic signed [WORD_W-1:0] new_next_pc;
   logic [SLOTS-1:0]         ins_sel;
   logic [SLOTS-1:0]         busy_eff;
   logic signed [WORD_W-1:0] eff_from_pc [SLOTS];
   logic signed [WORD_W-1:0] eff_next_pc [SLOTS];
   logic [TAG_W-1:0]         eff_tag     [SLOTS];
   logic [AGE_W-1:0]         slot_age    [SLOTS];
   logic [SLOTS-1:0]         best_hit;
   logic [SLOTS-1:0]         kill;

   logic [AGE_W-1:0]         mod_lut [TAGS];
   logic [AGE_W-1:0]         head_mod;
   logic [AGE_W-1:0]         stag_mod;
   logic [SUM_W-1:0]         stag_sum;
   logic [AGE_W-1:0]         stag_age;

   logic                     node_ok  [NODES];
   logic [AGE_W-1:0]         node_age [NODES];
   logic [IDX_W-1:0]         node_idx [NODES];
   logic                     best_ok;
   logic [IDX_W-1:0]         best_idx;

   assign advance       = stage_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stage_valid_ff || advance;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

   for (genvar t = 0; t < TAGS; t++) begin : g_mod
      assign mod_lut[t] = AGE_W'(t % ROB_ENTRIES);
   end

   assign head_mod = mod_lut[stage_ff.rob_head];
   assign stag_mod = mod_lut[stage_ff.squash_tag];
   assign stag_sum = SUM_W'(stag_mod) + RANGE - SUM_W'(head_mod);
   assign stag_age = (stag_sum >= RANGE) ? AGE_W'(stag_sum - RANGE) : AGE_W'(stag_sum);

   always_comb begin
      case (stage_ff.cmd)
         CMD_EQ:  taken = stage_ff.first_operand == stage_ff.second_operand;
         CMD_NE:  taken = stage_ff.first_operand != stage_ff.second_operand;
         CMD_LT:  taken = stage_ff.first_operand < stage_ff.second_operand;
         CMD_GE:  taken = stage_ff.first_operand >= stage_ff.second_operand;
         CMD_LTU: taken = $unsigned(stage_ff.first_operand) < $unsigned(stage_ff.second_operand);
         CMD_GEU: taken = $unsigned(stage_ff.first_operand) >= $unsigned(stage_ff.second_operand);
         default: taken = 1'b0;
      endcase
   end

   assign new_next_pc = taken ? stage_ff.branch_pc + stage_ff.offset
                              : stage_ff.branch_pc + PC_STEP;

   always_comb begin
      logic found;
      found   = 1'b0;
      ins_sel = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_busy_ff[i] && !found) begin
            ins_sel[i] = stage_ff.dispatch_valid;
            found      = 1'b1;
         end
      end
   end

   assign busy_eff = slot_busy_ff | ins_sel;

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      logic [SUM_W-1:0] age_sum;
      assign eff_from_pc[i] = ins_sel[i] ? stage_ff.branch_pc : slot_from_pc_ff[i];
      assign eff_next_pc[i] = ins_sel[i] ? new_next_pc : slot_next_pc_ff[i];
      assign eff_tag[i]     = ins_sel[i] ? stage_ff.branch_tag : slot_tag_ff[i];
      assign age_sum        = SUM_W'(mod_lut[eff_tag[i]]) + RANGE - SUM_W'(head_mod);
      assign slot_age[i]    = (age_sum >= RANGE) ? AGE_W'(age_sum - RANGE) : AGE_W'(age_sum);
      assign best_hit[i]    = best_ok && (best_idx == IDX_W'(i));
      assign kill[i]        = stage_ff.squash_valid && (slot_age[i] >= stag_age);
   end

   for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
      if (l < SLOTS) begin : g_used
         assign node_ok[LEAVES-1+l]  = busy_eff[l];
         assign node_age[LEAVES-1+l] = slot_age[l];
         assign node_idx[LEAVES-1+l] = IDX_W'(l);
      end else begin : g_pad
         assign node_ok[LEAVES-1+l]  = 1'b0;
         assign node_age[LEAVES-1+l] = '0;
         assign node_idx[LEAVES-1+l] = '0;
      end
   end

   for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
      logic pick_right;
      assign pick_right  = node_ok[2*n+2] &&
                           (!node_ok[2*n+1] || (node_age[2*n+2] < node_age[2*n+1]));
      assign node_ok[n]  = node_ok[2*n+1] || node_ok[2*n+2];
      assign node_age[n] = pick_right ? node_age[2*n+2] : node_age[2*n+1];
      assign node_idx[n] = pick_right ? node_idx[2*n+2] : node_idx[2*n+1];
   end

   assign best_ok  = node_ok[0];
   assign best_idx = node_idx[0];

   always_comb begin
      rsp_in.writeback_valid = best_ok;
      rsp_in.from_pc         = best_ok ? eff_from_pc[best_idx] : '0;
      rsp_in.next_pc         = best_ok ? eff_next_pc[best_idx] : '0;
      rsp_in.result_tag      = best_ok ? eff_tag[best_idx] : '0;
      slot_busy_in           = busy_eff & ~best_hit & ~kill;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         slot_busy_ff   <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            slot_busy_ff <= slot_busy_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         stage_ff <= req_bus.data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < SLOTS; i++) begin
            if (ins_sel[i]) begin
               slot_from_pc_ff[i] <= stage_ff.branch_pc;
               slot_next_pc_ff[i] <= new_next_pc;
               slot_tag_ff[i]     <= stage_ff.branch_tag;
            end
         end
      end
   end

endmodule

`default_nettype wire
